>>> sv/gfr_pkg.sv
`timescale 1ns / 1ps
package gfr_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int SHIFT_W    = $clog2(DATA_WIDTH);
  localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

  typedef enum logic [1:0] {
    OP_GCD2   = 2'd0,
    OP_GCD3   = 2'd1,
    OP_REDUCE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture request, clear results
    logic gcd_step;    // one binary-gcd step
    logic save_g;      // latch gcd result
    logic load_third;  // restart gcd on (result, third value)
    logic div_load_a;  // start dividing numerator by divisor
    logic div_load_b;  // start dividing denominator by divisor
    logic div_step;    // one restoring-division step
    logic store_qa;
    logic store_qb;
  } gfr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic gcd_done;
    logic g_zero;
    logic div_done;
  } gfr_status_t;

endpackage

>>> sv/gcd_and_fraction_reducer_unit.sv
`timescale 1ns / 1ps
// channel   ports                                     transfer when
// request   in_operation, in_*_value                  start && !busy
// result    out_divisor, out_reduced_first/_second    out_valid (one cycle)
//
// Steps: load, then a binary-gcd pass (one shift or subtract per cycle),
// a second pass for the three-value divisor, the two restoring divisions
// of a reduction, and the result cycle.
// Reset is synchronous, active low, and returns the controller to idle.
// The result is presented for one cycle only; the receiver cannot stall.
module gcd_and_fraction_reducer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_operation,
  input  logic [gfr_pkg::DATA_WIDTH-1:0] in_first_value,
  input  logic [gfr_pkg::DATA_WIDTH-1:0] in_second_value,
  input  logic [gfr_pkg::DATA_WIDTH-1:0] in_third_value,
  output logic                           out_valid,
  output logic [gfr_pkg::DATA_WIDTH-1:0] out_divisor,
  output logic [gfr_pkg::DATA_WIDTH-1:0] out_reduced_first,
  output logic [gfr_pkg::DATA_WIDTH-1:0] out_reduced_second
);
  import gfr_pkg::*;

  gfr_cmd_t    cmd;
  gfr_status_t status;

  gfr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .out_valid    (out_valid)
  );

  gfr_datapath u_dp (
    .clk                (clk),
    .cmd                (cmd),
    .in_operation       (in_operation),
    .in_first_value     (in_first_value),
    .in_second_value    (in_second_value),
    .in_third_value     (in_third_value),
    .status             (status),
    .out_divisor        (out_divisor),
    .out_reduced_first  (out_reduced_first),
    .out_reduced_second (out_reduced_second)
  );

endmodule

>>> sv/gfr_datapath.sv
`timescale 1ns / 1ps
module gfr_datapath (
  input  logic                          clk,
  input  gfr_pkg::gfr_cmd_t             cmd,
  input  logic [1:0]                    in_operation,
  input  logic [gfr_pkg::DATA_WIDTH-1:0] in_first_value,
  input  logic [gfr_pkg::DATA_WIDTH-1:0] in_second_value,
  input  logic [gfr_pkg::DATA_WIDTH-1:0] in_third_value,
  output gfr_pkg::gfr_status_t          status,
  output logic [gfr_pkg::DATA_WIDTH-1:0] out_divisor,
  output logic [gfr_pkg::DATA_WIDTH-1:0] out_reduced_first,
  output logic [gfr_pkg::DATA_WIDTH-1:0] out_reduced_second
);
  import gfr_pkg::*;

  localparam int W = DATA_WIDTH;

  op_t              op_r;
  logic [W-1:0]     a_r, b_r, c_r;
  logic [W-1:0]     x_r, x_nxt, y_r, y_nxt;
  logic [SHIFT_W-1:0] k_r, k_nxt;
  logic [W-1:0]     g_r, rf_r, rs_r;
  logic [W-1:0]     rem_r, rem_nxt, q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [W-1:0] gcd_res;
  logic [W:0]   xy_diff;
  logic [W:0]   rem_shift, rem_diff;

  assign gcd_res = (x_r | y_r) << k_r;
  assign xy_diff = {1'b0, x_r} - {1'b0, y_r};

  // binary gcd step: pull out common twos, then halve the even one,
  // else subtract the smaller odd from the larger and halve
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    k_nxt = k_r;
    if (!x_r[0] && !y_r[0]) begin
      x_nxt = x_r >> 1;
      y_nxt = y_r >> 1;
      k_nxt = k_r + SHIFT_W'(1);
    end else if (!x_r[0]) begin
      x_nxt = x_r >> 1;
    end else if (!y_r[0]) begin
      y_nxt = y_r >> 1;
    end else if (!xy_diff[W]) begin
      x_nxt = xy_diff[W:1];
    end else begin
      y_nxt = W'((~xy_diff + 1'b1) >> 1);
    end
  end

  // restoring division, one quotient bit per cycle
  assign rem_shift = {rem_r, q_r[W-1]};
  assign rem_diff  = rem_shift - {1'b0, g_r};

  always_comb begin
    rem_nxt = rem_diff[W] ? rem_shift[W-1:0] : rem_diff[W-1:0];
    q_nxt   = {q_r[W-2:0], ~rem_diff[W]};
    cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op_t'(in_operation);
      a_r  <= in_first_value;
      b_r  <= in_second_value;
      c_r  <= in_third_value;
      x_r  <= in_first_value;
      y_r  <= in_second_value;
      k_r  <= '0;
      g_r  <= '0;
      rf_r <= '0;
      rs_r <= '0;
    end else if (cmd.load_third) begin
      x_r <= gcd_res;
      y_r <= c_r;
      k_r <= '0;
    end else if (cmd.gcd_step) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      k_r <= k_nxt;
    end
    if (cmd.save_g) begin
      g_r <= gcd_res;
    end
    if (cmd.store_qa) begin
      rf_r <= q_r;
    end
    if (cmd.store_qb) begin
      rs_r <= q_r;
    end
    if (cmd.div_load_a || cmd.div_load_b) begin
      rem_r <= '0;
      q_r   <= cmd.div_load_a ? a_r : b_r;
      cnt_r <= CNT_W'(W);
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign status.op       = op_r;
  assign status.gcd_done = (x_r == '0) || (y_r == '0);
  assign status.g_zero   = (gcd_res == '0);
  assign status.div_done = (cnt_r == '0);

  assign out_divisor        = g_r;
  assign out_reduced_first  = rf_r;
  assign out_reduced_second = rs_r;

endmodule

>>> sv/gfr_ctrl.sv
`timescale 1ns / 1ps
module gfr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           in_operation,
  input  gfr_pkg::gfr_status_t status,
  output gfr_pkg::gfr_cmd_t    cmd,
  output logic                 busy,
  output logic                 out_valid
);
  import gfr_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_GCD1 = 6'b000010,
    ST_GCD2 = 6'b000100,
    ST_DIVA = 6'b001000,
    ST_DIVB = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (op_t'(in_operation) == OP_NONE) ? ST_DONE : ST_GCD1;
        end
      end
      ST_GCD1: begin
        if (!status.gcd_done) begin
          cmd.gcd_step = 1'b1;
        end else begin
          cmd.save_g = 1'b1;
          unique case (status.op)
            OP_GCD3: begin
              cmd.load_third = 1'b1;
              state_nxt      = ST_GCD2;
            end
            OP_REDUCE: begin
              if (status.g_zero) begin
                state_nxt = ST_DONE;
              end else begin
                cmd.div_load_a = 1'b1;
                state_nxt      = ST_DIVA;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_GCD2: begin
        if (!status.gcd_done) begin
          cmd.gcd_step = 1'b1;
        end else begin
          cmd.save_g = 1'b1;
          state_nxt  = ST_DONE;
        end
      end
      ST_DIVA: begin
        if (!status.div_done) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.store_qa   = 1'b1;
          cmd.div_load_b = 1'b1;
          state_nxt      = ST_DIVB;
        end
      end
      ST_DIVB: begin
        if (!status.div_done) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.store_qb = 1'b1;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

endmodule

>>> sv/gfr_checker.sv
`timescale 1ns / 1ps
module gfr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic [gfr_pkg::DATA_WIDTH-1:0] out_divisor,
  input logic [gfr_pkg::DATA_WIDTH-1:0] out_reduced_first,
  input logic [gfr_pkg::DATA_WIDTH-1:0] out_reduced_second
);
  import gfr_pkg::*;

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result not followed by idle");

  // an accepted request always starts work, even an unused operation code, which goes straight to the result cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not start work");

  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_divisor == '0) |->
      (out_reduced_first == '0) && (out_reduced_second == '0))
    else $error("reduced terms nonzero with zero divisor");

endmodule

bind gcd_and_fraction_reducer_unit gfr_checker u_gfr_checker (.*);
